// ----- rtl/bpf_pkg.sv -----
// Package for the byte pipe FIFO: ring geometry, request and status codes,
// and the packed item types of the request and result channels. No dependencies.
`default_nettype none
package bpf_pkg;

    localparam int DEPTH  = 4096;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CNT_W  = 13;
    localparam int AVAIL_MAX = (1 << CNT_W) - 1;

    // request codes; unused codes act as a query
    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_POP       = 3'd1;
    localparam logic [2:0] REQ_CLOSE_RD  = 3'd2;
    localparam logic [2:0] REQ_CLOSE_WR  = 3'd3;
    localparam logic [2:0] REQ_QUERY     = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_EOS   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EPIPE = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] wr_data;
    } req_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       rd_data;
        logic [CNT_W-1:0] avail_count;
        logic             readable;
        logic             writable;
        logic             hung_up;
        logic             last_end_closed;
    } rsp_item_t;

endpackage
`default_nettype wire

// ----- rtl/bpf_ram.sv -----
// Byte ring storage: one write port, one read port with registered data.
// Depends on bpf_pkg for depth and pointer width.
`default_nettype none
module bpf_ram
    import bpf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire logic [7:0]       wr_data,
    input  wire logic             rd_en,
    input  wire logic [PTR_W-1:0] rd_addr,
    output logic      [7:0]       rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/byte_pipe_fifo_with_hangup_core.sv -----
// Byte pipe FIFO with read/write end hang-up tracking; uses bpf_pkg and bpf_ram.
// A result passes through stage 1 (with the RAM read) and then the result reg.
// Throughput: one request per cycle, limited only by m_ready backpressure.
// Reset (aresetn, sync, active low): empty ring, both ends open, pipeline empty.
// Ring contents are not cleared; only entries already pushed are ever read.
`default_nettype none
module byte_pipe_fifo_with_hangup_core
    import bpf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire req_item_t s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output rsp_item_t      m_item
);

    // ------------------------------------------------------------------
    // FIFO state. All of it updates at the edge the request is accepted,
    // so the next request already sees the new pointers and flags.
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg,  wr_ptr_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic              rd_open_reg, rd_open_next;
    logic              wr_open_reg, wr_open_next;
    logic [1:0]        open_cnt_reg, open_cnt_next;

    // stage 1: result fields minus the popped byte, which the RAM supplies
    logic      s1_valid_reg;
    rsp_item_t s1_item_reg, s1_item_next;
    logic      s1_pop_reg,  s1_pop_next;

    // stage 2: result register facing the m_ channel
    logic      m_valid_reg;
    rsp_item_t m_item_reg, m_item_next;

    logic       accept;
    logic       s1_advance;
    logic       ram_wr_en;
    logic       ram_rd_en;
    logic [7:0] ram_rd_data;
    logic       full;
    logic       empty;

    // pipeline moves whenever the result register is free or being drained
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;

    assign full  = (fill_reg >= FILL_W'(DEPTH));
    assign empty = (fill_reg == '0);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        // wraps from DEPTH-1 to 0 also for non-power-of-two depths
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // ------------------------------------------------------------------
    // Request decode and next state
    // ------------------------------------------------------------------
    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        rd_open_next  = rd_open_reg;
        wr_open_next  = wr_open_reg;
        open_cnt_next = open_cnt_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        s1_pop_next   = 1'b0;
        s1_item_next  = '0;
        s1_item_next.status = ST_OK;

        case (s_item.req_type)
            REQ_PUSH: begin
                // closed reader wins over full
                if (!rd_open_reg) begin
                    s1_item_next.status = ST_EPIPE;
                end else if (full) begin
                    s1_item_next.status = ST_FULL;
                end else begin
                    ram_wr_en   = accept;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    fill_next   = fill_reg + FILL_W'(1);
                end
            end
            REQ_POP: begin
                if (empty) begin
                    s1_item_next.status = wr_open_reg ? ST_EMPTY : ST_EOS;
                end else begin
                    ram_rd_en   = accept;
                    s1_pop_next = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    fill_next   = fill_reg - FILL_W'(1);
                end
            end
            REQ_CLOSE_RD: begin
                // closing an already closed end changes nothing
                if (rd_open_reg) begin
                    rd_open_next = 1'b0;
                    if (open_cnt_reg != 2'd0) begin
                        open_cnt_next = open_cnt_reg - 2'd1;
                        s1_item_next.last_end_closed = (open_cnt_reg == 2'd1);
                    end
                end
            end
            REQ_CLOSE_WR: begin
                if (wr_open_reg) begin
                    wr_open_next = 1'b0;
                    if (open_cnt_reg != 2'd0) begin
                        open_cnt_next = open_cnt_reg - 2'd1;
                        s1_item_next.last_end_closed = (open_cnt_reg == 2'd1);
                    end
                end
            end
            default: begin
                // query and unused codes: report only
            end
        endcase

        // flags and count reflect the state after this request
        if (32'(fill_next) > 32'(AVAIL_MAX)) begin
            s1_item_next.avail_count = CNT_W'(AVAIL_MAX);
        end else begin
            s1_item_next.avail_count = CNT_W'(fill_next);
        end
        s1_item_next.readable = (fill_next != '0) || !wr_open_next;
        s1_item_next.writable = (fill_next < FILL_W'(DEPTH)) && rd_open_next;
        s1_item_next.hung_up  = !wr_open_next;
    end

    // ------------------------------------------------------------------
    // Ring storage. A pop only reads entries pushed at an earlier edge,
    // so no read-during-write bypass is needed.
    // ------------------------------------------------------------------
    bpf_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_item.wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            rd_open_reg  <= 1'b1;
            wr_open_reg  <= 1'b1;
            open_cnt_reg <= 2'd2;
        end else if (accept) begin
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            rd_open_reg  <= rd_open_next;
            wr_open_reg  <= wr_open_next;
            open_cnt_reg <= open_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: held while stalled; the RAM read register holds alongside
    // because it only loads on an accepted pop.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s1_item_next;
            s1_pop_reg  <= s1_pop_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result register; merge in the popped byte
    // ------------------------------------------------------------------
    always_comb begin
        m_item_next         = s1_item_reg;
        m_item_next.rd_data = s1_pop_reg ? ram_rd_data : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire
